### hdl/middle_insert_queue_macros.svh
// Assertion macros for the middle_insert_queue checker.
// Used by miq_checker.sv; no other dependencies.
`ifndef MIDDLE_INSERT_QUEUE_MACROS_SVH
`define MIDDLE_INSERT_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MIQ_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("miq checker: same-cycle property failed");

// Next-cycle implication, checked also through reset.
`define MIQ_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("miq checker: next-cycle property failed");

`endif

### hdl/miq_pkg.sv
// Shared types and constants for the middle insertion queue.
// No dependencies; imported by every module of the block but miq_ram.
`timescale 1ns / 1ps

package miq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int STS_W        = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK = 2'd0,
        CMD_PUSH_MID  = 2'd1,
        CMD_POP       = 2'd2,
        CMD_NOP       = 2'd3
    } miq_cmd_e_t;

    typedef enum logic [STS_W-1:0] {
        STS_PUSH_OK    = 2'd0,
        STS_POPPED     = 2'd1,
        STS_POP_EMPTY  = 2'd2,
        STS_PUSH_FULL  = 2'd3
    } miq_sts_e_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch word, issue RAM reads
        logic commit;    // apply update, load result
    } miq_ctrl_t;

endpackage

### hdl/miq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module miq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/miq_ctrl.sv
// Controller FSM: accept a word, run the execute state, hand off the result.
// Depends on miq_pkg.
`timescale 1ns / 1ps

module miq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output miq_pkg::miq_ctrl_t ctrl
);
    import miq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == ST_IDLE);
    assign ctrl.capture = s_valid && s_ready;
    assign ctrl.commit  = (state_reg == ST_EXEC) && out_free;
    assign m_valid      = m_valid_reg;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (ctrl.capture) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (ctrl.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### hdl/miq_datapath.sv
// Datapath: two ring-buffer halves in RAM, their pointers and counts, result regs.
// Depends on miq_pkg and miq_ram.
`timescale 1ns / 1ps

module miq_datapath #(
    parameter int CAPACITY = miq_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  miq_pkg::miq_ctrl_t                ctrl,
    input  logic [miq_pkg::CMD_W-1:0]         in_command,
    input  logic signed [miq_pkg::DATA_W-1:0] in_value,
    output logic [miq_pkg::STS_W-1:0]         out_status,
    output logic signed [miq_pkg::DATA_W-1:0] out_popped
);
    import miq_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = PTR_W + 1;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
    localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);
    localparam logic [CNT_W:0]   CAP_TOT  = (CNT_W + 1)'(CAPACITY);

    miq_cmd_e_t        cmd_reg;
    logic [DATA_W-1:0] value_reg;
    logic [PTR_W-1:0]  fh_reg, fh_next;
    logic [CNT_W-1:0]  fc_reg, fc_next;
    logic [PTR_W-1:0]  bh_reg, bh_next;
    logic [PTR_W-1:0]  bt_reg, bt_next;
    logic [CNT_W-1:0]  bc_reg, bc_next;
    miq_sts_e_t        status_reg, status_next;
    logic [DATA_W-1:0] popped_reg, popped_next;

    logic [DATA_W-1:0] f_rdata, b_rdata;
    logic              f_we, b_we;
    logic [DATA_W-1:0] f_wdata;
    logic [PTR_W-1:0]  b_waddr;
    logic [PTR_W-1:0]  fe_addr;
    logic [SUM_W-1:0]  fe_sum;
    logic [PTR_W-1:0]  fh_inc, bh_inc, bh_dec, bt_inc;
    logic [CNT_W:0]    total;
    logic              full, balanced;

    // end of the front half: front head + front count, mod CAPACITY
    assign fe_sum  = SUM_W'(fh_reg) + SUM_W'(fc_reg);
    assign fe_addr = (fe_sum >= CAP_SUM) ? PTR_W'(fe_sum - CAP_SUM) : PTR_W'(fe_sum);

    assign fh_inc = (fh_reg == PTR_LAST) ? '0 : fh_reg + 1'b1;
    assign bh_inc = (bh_reg == PTR_LAST) ? '0 : bh_reg + 1'b1;
    assign bt_inc = (bt_reg == PTR_LAST) ? '0 : bt_reg + 1'b1;
    assign bh_dec = (bh_reg == '0) ? PTR_LAST : bh_reg - 1'b1;

    assign total    = (CNT_W + 1)'(fc_reg) + (CNT_W + 1)'(bc_reg);
    assign full     = (total >= CAP_TOT);
    // halves equal: the next push spills into the front half
    assign balanced = (fc_reg == bc_reg);

    always_comb begin
        fh_next     = fh_reg;
        fc_next     = fc_reg;
        bh_next     = bh_reg;
        bt_next     = bt_reg;
        bc_next     = bc_reg;
        status_next = STS_PUSH_OK;
        popped_next = '0;
        f_we        = 1'b0;
        f_wdata     = value_reg;
        b_we        = 1'b0;
        b_waddr     = bt_reg;
        if (ctrl.commit) begin
            case (cmd_reg)
                CMD_PUSH_BACK: begin
                    if (full) begin
                        status_next = STS_PUSH_FULL;
                    end else if (balanced && (bc_reg == '0)) begin
                        // empty queue: word lands straight in the front half
                        f_we    = 1'b1;
                        fc_next = fc_reg + 1'b1;
                    end else if (balanced) begin
                        // append, and move the back head into the front half
                        b_we    = 1'b1;
                        bt_next = bt_inc;
                        f_we    = 1'b1;
                        f_wdata = b_rdata;
                        bh_next = bh_inc;
                        fc_next = fc_reg + 1'b1;
                    end else begin
                        b_we    = 1'b1;
                        bt_next = bt_inc;
                        bc_next = bc_reg + 1'b1;
                    end
                end
                CMD_PUSH_MID: begin
                    if (full) begin
                        status_next = STS_PUSH_FULL;
                    end else if (balanced) begin
                        // new word would move on at once: write it to the front end
                        f_we    = 1'b1;
                        fc_next = fc_reg + 1'b1;
                    end else begin
                        b_we    = 1'b1;
                        b_waddr = bh_dec;
                        bh_next = bh_dec;
                        bc_next = bc_reg + 1'b1;
                    end
                end
                CMD_POP: begin
                    if (fc_reg == '0) begin
                        status_next = STS_POP_EMPTY;
                    end else begin
                        status_next = STS_POPPED;
                        popped_next = f_rdata;
                        fh_next     = fh_inc;
                        if (balanced) begin
                            f_we    = 1'b1;
                            f_wdata = b_rdata;
                            bh_next = bh_inc;
                            bc_next = bc_reg - 1'b1;
                        end else begin
                            fc_next = fc_reg - 1'b1;
                        end
                    end
                end
                default: begin
                    status_next = STS_PUSH_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            fh_reg <= '0;
            fc_reg <= '0;
            bh_reg <= '0;
            bt_reg <= '0;
            bc_reg <= '0;
        end else begin
            fh_reg <= fh_next;
            fc_reg <= fc_next;
            bh_reg <= bh_next;
            bt_reg <= bt_next;
            bc_reg <= bc_next;
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.capture) begin
            cmd_reg   <= miq_cmd_e_t'(in_command);
            value_reg <= $unsigned(in_value);
        end
        if (ctrl.commit) begin
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
    end

    miq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_front_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (fe_addr),
        .wdata (f_wdata),
        .re    (ctrl.capture),
        .raddr (fh_reg),
        .rdata (f_rdata)
    );

    miq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_back_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (value_reg),
        .re    (ctrl.capture),
        .raddr (bh_reg),
        .rdata (b_rdata)
    );

    assign out_status = status_reg;
    assign out_popped = $signed(popped_reg);

endmodule

### hdl/middle_insert_queue.sv
// Middle insertion queue: m_valid is registered, set when the execute state commits;
// the commit waits until the output register is empty or being drained.
// Words are taken one at a time: the accept cycle issues the RAM reads
// at both half heads, the execute cycle writes back and loads the result register.
// A waiting result does not block the next accept; only its execute cycle waits.
// Reset (aresetn, sync, active low) clears pointers, counts and handshake state;
// the stores are not cleared and there is no clearing pass.
`timescale 1ns / 1ps

module middle_insert_queue #(
    parameter int CAPACITY = miq_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words: command plus push value
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [miq_pkg::CMD_W-1:0]         s_command,
    input  logic signed [miq_pkg::DATA_W-1:0] s_value,
    // result words: one per input word
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [miq_pkg::STS_W-1:0]         m_status,
    output logic signed [miq_pkg::DATA_W-1:0] m_popped_value
);
    import miq_pkg::*;

    miq_ctrl_t ctrl;

    // Controller: IDLE takes a word, EXEC commits once the output register
    // is free (empty, or being drained this cycle).
    miq_ctrl u_ctrl (
        .clk     (aclk),
        .rst_n   (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    // Datapath: front half holds the first ceil(n/2) entries, back half the
    // rest; each command moves at most one entry across the middle.
    miq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (aclk),
        .rst_n      (aresetn),
        .ctrl       (ctrl),
        .in_command (s_command),
        .in_value   (s_value),
        .out_status (m_status),
        .out_popped (m_popped_value)
    );

endmodule

### hdl/miq_checker.sv
// Port-level checker for middle_insert_queue, attached by bind.
// Depends on miq_pkg and middle_insert_queue_macros.svh.
`timescale 1ns / 1ps
`include "middle_insert_queue_macros.svh"

module miq_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [miq_pkg::CMD_W-1:0]         s_command,
    input logic signed [miq_pkg::DATA_W-1:0] s_value,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [miq_pkg::STS_W-1:0]         m_status,
    input logic signed [miq_pkg::DATA_W-1:0] m_popped_value
);
    import miq_pkg::*;

    logic                    s_fire;
    logic                    s_wait;
    logic                    m_stall;
    logic                    m_nodata;
    logic [CMD_W+DATA_W-1:0] s_word;
    logic [STS_W+DATA_W-1:0] m_word;

    assign s_fire   = s_valid && s_ready;
    assign s_wait   = s_valid && !s_ready;
    assign m_stall  = m_valid && !m_ready;
    assign m_nodata = m_valid && (m_status != STS_POPPED);
    assign s_word   = {s_command, s_value};
    assign m_word   = {m_status, m_popped_value};

    // a held-back input word keeps its payload
    `MIQ_ASSERT_NEXT(a_in_hold, aclk, aresetn && s_wait, s_valid && $stable(s_word))
    // a stalled result holds
    `MIQ_ASSERT_NEXT(a_out_hold, aclk, aresetn && m_stall, m_valid && $stable(m_word))
    // popped value is zero unless a pop succeeded
    `MIQ_ASSERT_IMPLY(a_pop_zero, aclk, aresetn, m_nodata, m_popped_value == 0)
    // each accepted word occupies the execute state before the next accept
    `MIQ_ASSERT_NEXT(a_one_inflight, aclk, aresetn && s_fire, !s_ready)
    // no result right after reset
    `MIQ_ASSERT_NEXT(a_reset_idle, aclk, !aresetn, !m_valid)

endmodule

bind middle_insert_queue miq_checker u_miq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_command      (s_command),
    .s_value        (s_value),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_popped_value (m_popped_value)
);
